// File: rtl/core/agit_pkg.sv
// shared types, codes and the arctangent table of the angle gain interpolation table
package agit_pkg;

  // operation codes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_NO_END = 2'd2;
  localparam logic [1:0] ST_DUP    = 2'd3;

  localparam int ATAN_LEN   = 24;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_W      = 49;
  localparam int CNT_W      = 6;

  typedef struct packed {
    logic [1:0]         op;
    logic [15:0]        entry_angle;
    logic [31:0]        entry_gain;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] gain;
    logic [15:0] angle;
  } out_item_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic take_in;
    logic clr_count;
    logic ins_eval;
    logic ins_chk;
    logic sh_rd;
    logic sh_wr;
    logic put;
    logic sq_y;
    logic sq_z;
    logic cos;
    logic rad;
    logic sqrt_step;
    logic cinit;
    logic cord_step;
    logic code;
    logic q_eval;
    logic q_sel;
    logic mul;
    logic dinit;
    logic div_step;
    logic fin;
    logic load_out;
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [1:0] op;
    logic       count_zero;
    logic       last_k;
    logic       ev_dup;
    logic       full;
    logic       k_gt_pos;
    logic       sqrt_last;
    logic       cord_last;
    logic       div_last;
    logic       ends_ok;
    logic       same_idx;
    logic       out_busy;
  } dp_stat_t;

  // arctangent of 2^-i, 180 degrees = 2^31
  function automatic logic [29:0] atan_unit(input logic [4:0] idx);
    logic [29:0] r;
    case (idx)
      5'd0:  r = 30'h20000000;
      5'd1:  r = 30'h12E4051E;
      5'd2:  r = 30'h09FB385B;
      5'd3:  r = 30'h051111D4;
      5'd4:  r = 30'h028B0D43;
      5'd5:  r = 30'h0145D7E1;
      5'd6:  r = 30'h00A2F61E;
      5'd7:  r = 30'h00517C55;
      5'd8:  r = 30'h0028BE53;
      5'd9:  r = 30'h00145F2F;
      5'd10: r = 30'h000A2F98;
      5'd11: r = 30'h000517CC;
      5'd12: r = 30'h00028BE6;
      5'd13: r = 30'h000145F3;
      5'd14: r = 30'h0000A2FA;
      5'd15: r = 30'h0000517D;
      5'd16: r = 30'h000028BE;
      5'd17: r = 30'h0000145F;
      5'd18: r = 30'h00000A30;
      5'd19: r = 30'h00000518;
      5'd20: r = 30'h0000028C;
      5'd21: r = 30'h00000146;
      5'd22: r = 30'h000000A3;
      5'd23: r = 30'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/agit_ctrl.sv
// sequencing state machine of the angle gain interpolation table
module agit_ctrl
  import agit_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [23:0] {
    S_IDLE  = 24'h000001,
    S_CLR   = 24'h000002,
    S_INSRD = 24'h000004,
    S_INSEV = 24'h000008,
    S_INSCK = 24'h000010,
    S_SHRD  = 24'h000020,
    S_SHWR  = 24'h000040,
    S_PUT   = 24'h000080,
    S_SQY   = 24'h000100,
    S_SQZ   = 24'h000200,
    S_COS   = 24'h000400,
    S_RAD   = 24'h000800,
    S_SQRT  = 24'h001000,
    S_CINIT = 24'h002000,
    S_CORD  = 24'h004000,
    S_CODE  = 24'h008000,
    S_QRD   = 24'h010000,
    S_QEV   = 24'h020000,
    S_QSEL  = 24'h040000,
    S_MUL   = 24'h080000,
    S_DINIT = 24'h100000,
    S_DIV   = 24'h200000,
    S_FIN   = 24'h400000,
    S_RESP  = 24'h800000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          case (stat.op)
            OP_CLEAR:  state_nxt = S_CLR;
            OP_INSERT: state_nxt = stat.count_zero ? S_INSCK : S_INSRD;
            OP_QUERY:  state_nxt = S_SQY;
            default:   state_nxt = S_RESP;
          endcase
        end
      end
      S_CLR: begin
        cmd.clr_count = 1'b1;
        state_nxt     = S_RESP;
      end
      S_INSRD: state_nxt = S_INSEV;
      S_INSEV: begin
        cmd.ins_eval = 1'b1;
        if (stat.ev_dup)      state_nxt = S_RESP;
        else if (stat.last_k) state_nxt = S_INSCK;
        else                  state_nxt = S_INSRD;
      end
      S_INSCK: begin
        cmd.ins_chk = 1'b1;
        state_nxt   = stat.full ? S_RESP : S_SHRD;
      end
      S_SHRD: begin
        cmd.sh_rd = 1'b1;
        state_nxt = stat.k_gt_pos ? S_SHWR : S_PUT;
      end
      S_SHWR: begin
        cmd.sh_wr = 1'b1;
        state_nxt = S_SHRD;
      end
      S_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = S_RESP;
      end
      S_SQY: begin
        cmd.sq_y  = 1'b1;
        state_nxt = S_SQZ;
      end
      S_SQZ: begin
        cmd.sq_z  = 1'b1;
        state_nxt = S_COS;
      end
      S_COS: begin
        cmd.cos   = 1'b1;
        state_nxt = S_RAD;
      end
      S_RAD: begin
        cmd.rad   = 1'b1;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (stat.sqrt_last) state_nxt = S_CINIT;
      end
      S_CINIT: begin
        cmd.cinit = 1'b1;
        state_nxt = S_CORD;
      end
      S_CORD: begin
        cmd.cord_step = 1'b1;
        if (stat.cord_last) state_nxt = S_CODE;
      end
      S_CODE: begin
        cmd.code  = 1'b1;
        state_nxt = stat.count_zero ? S_RESP : S_QRD;
      end
      S_QRD: state_nxt = S_QEV;
      S_QEV: begin
        cmd.q_eval = 1'b1;
        state_nxt  = stat.last_k ? S_QSEL : S_QRD;
      end
      S_QSEL: begin
        cmd.q_sel = 1'b1;
        if (!stat.ends_ok || stat.same_idx) state_nxt = S_RESP;
        else                                state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.dinit = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// File: rtl/core/agit_dp.sv
// table memory, square root, cordic, search and divider datapath
module agit_dp
  import agit_pkg::*;
#(
  parameter int TABLE_ENTRIES = 32,
  parameter int CORDIC_STEPS  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int AW     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW     = $clog2(TABLE_ENTRIES + 1);
  localparam int NSTEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

  logic [47:0] tab_mem [TABLE_ENTRIES];
  logic [47:0] rdat_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [47:0]   wr_data;
  logic          wr_en;

  in_item_t item_r, item_nxt;
  logic [CW-1:0] count_r, count_nxt, k_r, k_nxt, pos_r, pos_nxt, km1;
  logic pos_set_r, pos_set_nxt;
  logic [1:0] ins_stat_r, ins_stat_nxt;
  logic [31:0] sq_r, sq_nxt;
  logic signed [31:0] c_r, c_nxt;
  logic [62:0] sv_r, sv_nxt, sres_r, sres_nxt;
  logic signed [33:0] x_r, x_nxt, cv_r, cv_nxt, acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0] code_r, code_nxt;
  logic has0_r, has0_nxt, has180_r, has180_nxt, hif_r, hif_nxt;
  logic [15:0] lo_ang_r, lo_ang_nxt, hi_ang_r, hi_ang_nxt;
  logic [31:0] lo_gain_r, lo_gain_nxt, hi_gain_r, hi_gain_nxt;
  logic [AW-1:0] lo_idx_r, lo_idx_nxt, hi_idx_r, hi_idx_nxt;
  logic [47:0] prod_r, prod_nxt;
  logic neg_r, neg_nxt;
  logic [15:0] den_r, den_nxt, rem_r, rem_nxt;
  logic [DIV_W-1:0] dq_r, dq_nxt;
  logic [31:0] gain_r, gain_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;

  logic [15:0] rd_ang;
  logic [31:0] rd_gain;
  logic signed [31:0] yy, zz;
  logic signed [33:0] cwide, sx, svs, at;
  logic [31:0] cneg;
  logic [30:0] cabs;
  logic [61:0] cc;
  logic [62:0] bitv, tsum;
  logic [5:0]  bsh;
  logic [31:0] accc;
  logic [47:0] mwide;
  logic [32:0] diff, dneg;
  logic [31:0] dabs;
  logic [15:0] adist;
  logic [16:0] remsh;
  logic [CW:0] kp1;

  assign rd_ang  = rdat_r[47:32];
  assign rd_gain = rdat_r[31:0];
  assign km1     = k_r - 1'b1;
  assign kp1     = {1'b0, k_r} + 1'b1;
  assign rd_addr = cmd.sh_rd ? km1[AW-1:0] : k_r[AW-1:0];
  assign wr_en   = cmd.sh_wr | cmd.put;
  assign wr_addr = cmd.put ? pos_r[AW-1:0] : k_r[AW-1:0];
  assign wr_data = cmd.put ? {item_r.entry_angle, item_r.entry_gain} : rdat_r;

  always_ff @(posedge clk) begin
    if (wr_en) tab_mem[wr_addr] <= wr_data;
    rdat_r <= tab_mem[rd_addr];
  end

  assign stat.op         = in_item.op;
  assign stat.count_zero = (count_r == '0);
  assign stat.last_k     = (kp1 == {1'b0, count_r});
  assign stat.ev_dup     = (rd_ang == item_r.entry_angle);
  assign stat.full       = (count_r == CW'(TABLE_ENTRIES));
  assign stat.k_gt_pos   = (k_r > pos_r);
  assign stat.sqrt_last  = (cnt_r == CNT_W'(SQRT_STEPS - 1));
  assign stat.cord_last  = (cnt_r == CNT_W'(NSTEPS - 1));
  assign stat.div_last   = (cnt_r == CNT_W'(DIV_W - 1));
  assign stat.ends_ok    = has0_r & has180_r;
  assign stat.same_idx   = (hi_idx_r == lo_idx_r);
  assign stat.out_busy   = out_valid_r & out_stall;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    yy    = $signed(item_r.quat_y) * $signed(item_r.quat_y);
    zz    = $signed(item_r.quat_z) * $signed(item_r.quat_z);
    cwide = 34'sh040000000 - $signed({1'b0, sq_r, 1'b0});
    cneg  = -c_r;
    cabs  = c_r[31] ? cneg[30:0] : c_r[30:0];
    cc    = cabs * cabs;
    bsh   = 6'd62 - {cnt_r[4:0], 1'b0};
    bitv  = 63'd1 << bsh;
    tsum  = sres_r + bitv;
    sx    = x_r >>> cnt_r[4:0];
    svs   = cv_r >>> cnt_r[4:0];
    at    = {4'b0, atan_unit(cnt_r[4:0])};
    if (acc_r[33])                  accc = '0;
    else if (acc_r > 34'sh80000000) accc = 32'h80000000;
    else                            accc = acc_r[31:0];
    mwide = {accc, 16'b0} - {16'b0, accc} + 48'h000040000000;
    diff  = {1'b0, hi_gain_r} - {1'b0, lo_gain_r};
    dneg  = -diff;
    dabs  = diff[32] ? dneg[31:0] : diff[31:0];
    adist = code_r - lo_ang_r;
    remsh = {rem_r, dq_r[DIV_W-1]};

    item_nxt = item_r;  count_nxt = count_r;  k_nxt = k_r;  pos_nxt = pos_r;
    pos_set_nxt = pos_set_r;  ins_stat_nxt = ins_stat_r;  sq_nxt = sq_r;  c_nxt = c_r;
    sv_nxt = sv_r;  sres_nxt = sres_r;  x_nxt = x_r;  cv_nxt = cv_r;  acc_nxt = acc_r;
    cnt_nxt = cnt_r;  code_nxt = code_r;  has0_nxt = has0_r;  has180_nxt = has180_r;
    hif_nxt = hif_r;  lo_ang_nxt = lo_ang_r;  hi_ang_nxt = hi_ang_r;
    lo_gain_nxt = lo_gain_r;  hi_gain_nxt = hi_gain_r;  lo_idx_nxt = lo_idx_r;
    hi_idx_nxt = hi_idx_r;  prod_nxt = prod_r;  neg_nxt = neg_r;  den_nxt = den_r;
    rem_nxt = rem_r;  dq_nxt = dq_r;  gain_nxt = gain_r;  out_nxt = out_r;
    out_valid_nxt = out_valid_r;

    if (cmd.take_in) begin
      item_nxt     = in_item;
      k_nxt        = '0;
      pos_set_nxt  = 1'b0;
      ins_stat_nxt = ST_OK;
      has0_nxt     = 1'b0;
      has180_nxt   = 1'b0;
      code_nxt     = '0;
      gain_nxt     = '0;
    end
    if (cmd.clr_count) count_nxt = '0;
    if (cmd.ins_eval) begin
      if (rd_ang == item_r.entry_angle) begin
        ins_stat_nxt = ST_DUP;
      end else if (rd_ang > item_r.entry_angle && !pos_set_r) begin
        pos_nxt     = k_r;
        pos_set_nxt = 1'b1;
      end
      k_nxt = kp1[CW-1:0];
    end
    if (cmd.ins_chk) begin
      if (!pos_set_r) pos_nxt = count_r;
      k_nxt = count_r;
      if (count_r == CW'(TABLE_ENTRIES)) ins_stat_nxt = ST_FULL;
    end
    if (cmd.sh_wr) k_nxt = km1;
    if (cmd.put) count_nxt = count_r + 1'b1;
    if (cmd.sq_y) sq_nxt = yy;
    if (cmd.sq_z) sq_nxt = sq_r + zz;
    if (cmd.cos) begin
      if (cwide < -34'sh040000000) c_nxt = -32'sh40000000;
      else                         c_nxt = cwide[31:0];
    end
    if (cmd.rad) begin
      sv_nxt   = (63'd1 << 60) - {1'b0, cc};
      sres_nxt = '0;
      cnt_nxt  = '0;
    end
    if (cmd.sqrt_step) begin
      if (sv_r >= tsum) begin
        sv_nxt   = sv_r - tsum;
        sres_nxt = (sres_r >> 1) + bitv;
      end else begin
        sres_nxt = sres_r >> 1;
      end
      cnt_nxt = cnt_r + 1'b1;
    end
    if (cmd.cinit) begin
      if (c_r[31]) begin
        x_nxt   = {3'b0, sres_r[30:0]};
        cv_nxt  = {3'b0, cabs};
        acc_nxt = 34'sh040000000;
      end else begin
        x_nxt   = {{2{c_r[31]}}, c_r};
        cv_nxt  = {3'b0, sres_r[30:0]};
        acc_nxt = '0;
      end
      cnt_nxt = '0;
    end
    if (cmd.cord_step) begin
      if (!cv_r[33]) begin
        x_nxt   = x_r + svs;
        cv_nxt  = cv_r - sx;
        acc_nxt = acc_r + at;
      end else begin
        x_nxt   = x_r - svs;
        cv_nxt  = cv_r + sx;
        acc_nxt = acc_r - at;
      end
      cnt_nxt = cnt_r + 1'b1;
    end
    if (cmd.code) begin
      code_nxt = mwide[46:31];
      k_nxt    = '0;
      hif_nxt  = 1'b0;
      lo_idx_nxt = '0;
    end
    if (cmd.q_eval) begin
      if (rd_ang == 16'h0000) has0_nxt = 1'b1;
      if (rd_ang == 16'hFFFF) has180_nxt = 1'b1;
      if (rd_ang <= code_r) begin
        lo_ang_nxt  = rd_ang;
        lo_gain_nxt = rd_gain;
        lo_idx_nxt  = k_r[AW-1:0];
      end
      if (!hif_r) begin
        // last entry stands in until one above the angle turns up
        hi_ang_nxt  = rd_ang;
        hi_gain_nxt = rd_gain;
        hi_idx_nxt  = k_r[AW-1:0];
        if (rd_ang > code_r) hif_nxt = 1'b1;
      end
      k_nxt = kp1[CW-1:0];
    end
    if (cmd.q_sel) gain_nxt = lo_gain_r;
    if (cmd.mul) begin
      prod_nxt = dabs * adist;
      neg_nxt  = diff[32];
      den_nxt  = hi_ang_r - lo_ang_r;
    end
    if (cmd.dinit) begin
      // half the divisor added ahead for round to nearest
      dq_nxt  = {1'b0, prod_r} + {{(DIV_W-15){1'b0}}, den_r[15:1]};
      rem_nxt = '0;
      cnt_nxt = '0;
    end
    if (cmd.div_step) begin
      if (remsh >= {1'b0, den_r}) begin
        rem_nxt = 16'(remsh - {1'b0, den_r});
        dq_nxt  = {dq_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = remsh[15:0];
        dq_nxt  = {dq_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
    end
    if (cmd.fin) gain_nxt = neg_r ? lo_gain_r - dq_r[31:0] : lo_gain_r + dq_r[31:0];

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
      case (item_r.op)
        OP_INSERT: begin
          out_nxt.status = ins_stat_r;
          out_nxt.gain   = '0;
          out_nxt.angle  = '0;
        end
        OP_QUERY: begin
          out_nxt.status = (has0_r && has180_r) ? ST_OK : ST_NO_END;
          out_nxt.gain   = (has0_r && has180_r) ? gain_r : '0;
          out_nxt.angle  = code_r;
        end
        default: out_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;  k_r <= k_nxt;  pos_r <= pos_nxt;  pos_set_r <= pos_set_nxt;
    ins_stat_r <= ins_stat_nxt;  sq_r <= sq_nxt;  c_r <= c_nxt;  sv_r <= sv_nxt;
    sres_r <= sres_nxt;  x_r <= x_nxt;  cv_r <= cv_nxt;  acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;  code_r <= code_nxt;  has0_r <= has0_nxt;  has180_r <= has180_nxt;
    hif_r <= hif_nxt;  lo_ang_r <= lo_ang_nxt;  hi_ang_r <= hi_ang_nxt;
    lo_gain_r <= lo_gain_nxt;  hi_gain_r <= hi_gain_nxt;  lo_idx_r <= lo_idx_nxt;
    hi_idx_r <= hi_idx_nxt;  prod_r <= prod_nxt;  neg_r <= neg_nxt;  den_r <= den_nxt;
    rem_r <= rem_nxt;  dq_r <= dq_nxt;  gain_r <= gain_nxt;  out_r <= out_nxt;
  end

endmodule

// File: rtl/core/angle_gain_interpolation_table.sv
// top level of the angle gain interpolation table
// Holds up to TABLE_ENTRIES (angle, Q16.16 gain) breakpoints in ascending
// angle order in a single-port-read table memory. One item is worked at a
// time: in_stall is high from the transfer of an item until its result has
// been put in the output register, which can still hold an earlier result
// waiting for its transfer. Insert compares each stored entry in turn for
// the position and, unless the angle is a duplicate or the table is full,
// moves each entry above it up one place. Query runs 32 square root steps,
// CORDIC_STEPS rotations (at most the arctangent table length), a search
// of the stored entries for the bracket and, when the angle falls between
// two breakpoints, 49 divider steps. The square root is bit-serial, the
// CORDIC iterative and the divider restoring; the one-read, one-write
// table memory makes search and shift go one entry at a time. Angle codes
// run 0 to 65535 for 0 to 180 degrees; a query needs both end breakpoints.
module angle_gain_interpolation_table
  import agit_pkg::*;
#(
  parameter int TABLE_ENTRIES = 32,
  parameter int CORDIC_STEPS  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  // item input channel
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  // result channel
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: decides which datapath step runs each cycle
  agit_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table memory, arithmetic units and output register
  agit_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .CORDIC_STEPS  (CORDIC_STEPS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// File: bench/tb_top.sv
// self-checking testbench for the angle gain interpolation table
module tb_top;
  import agit_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_ENTRIES = 32;
  localparam int CORDIC_STEPS  = 16;
  localparam int N_RANDOM      = 1670;
  localparam int STALL_LIMIT   = 20000;
  localparam logic [1:0] OP_NONE = 2'd3;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  angle_gain_interpolation_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // clock: 6 ns high, 6 ns low
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // predictor's own copy of the breakpoint table
  logic [15:0] tbl_angle [TABLE_ENTRIES];
  logic [31:0] tbl_gain  [TABLE_ENTRIES];
  int          tbl_count;

  out_item_t   pending_results [$];
  int          error_count;
  int          idle_cycles;
  bit          calm;        // last part of the run: no idling on either side
  bit          hold_off;    // long receiver stall to fill the block up

  // arctangent of 2^-i in units where 180 degrees is 2^31
  function automatic longint atan_step(input int i);
    longint t [24] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
    return t[i];
  endfunction

  // integer square root, bit by bit
  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res, bit_w;
    res   = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v   = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  // off-axis angle code from the y and z quaternion parts
  function automatic logic [15:0] off_axis_code(input logic signed [15:0] qy,
                                               input logic signed [15:0] qz);
    longint cosv, sinv, x, v, acc, nx;
    longint one_q30;
    one_q30 = 64'sd1 << 30;
    cosv = one_q30 - 2 * (longint'(qy) * qy + longint'(qz) * qz);
    if (cosv > one_q30) cosv = one_q30;
    if (cosv < -one_q30) cosv = -one_q30;
    sinv = longint'(root_floor(longint'((64'sd1 << 60) - cosv * cosv)));
    x   = cosv;
    v   = sinv;
    acc = 0;
    // second half of the circle: rotate by 90 degrees first
    if (x < 0) begin
      x   = sinv;
      v   = -cosv;
      acc = one_q30;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      // >>> on longint is a floor shift
      if (v >= 0) begin
        nx  = x + (v >>> i);
        v   = v - (x >>> i);
        acc = acc + atan_step(i);
      end else begin
        nx  = x - (v >>> i);
        v   = v + (x >>> i);
        acc = acc - atan_step(i);
      end
      x = nx;
    end
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 << 31)) acc = 64'sd1 << 31;
    return 16'((acc * 65535 + one_q30) >>> 31);
  endfunction

  // bracket the angle and interpolate the gain between breakpoints
  function automatic logic [31:0] gain_at(input logic [15:0] a);
    int     lo, hi;
    longint num, den, q, mag;
    lo = 0;
    for (int k = 0; k < tbl_count; k++)
      if (tbl_angle[k] <= a) lo = k;
    hi = tbl_count - 1;
    for (int k = tbl_count; k > 0; k--)
      if (tbl_angle[k-1] > a) hi = k - 1;
    if (hi == lo) return tbl_gain[lo];
    den = longint'(tbl_angle[hi]) - longint'(tbl_angle[lo]);
    if (den <= 0) return tbl_gain[lo];
    num = (longint'(tbl_gain[hi]) - longint'(tbl_gain[lo])) *
          (longint'(a) - longint'(tbl_angle[lo]));
    mag = num < 0 ? -num : num;
    // round half away from zero
    q   = (mag + den / 2) / den;
    if (num < 0) q = -q;
    return 32'(longint'(tbl_gain[lo]) + q);
  endfunction

  // apply one item to the table copy and give the result it causes
  function automatic out_item_t table_step(input in_item_t it);
    out_item_t r;
    int        pos;
    bit        has0, has180;
    r = '0;
    case (it.op)
      OP_CLEAR: tbl_count = 0;
      OP_INSERT: begin
        pos = tbl_count;
        for (int k = 0; k < tbl_count; k++) begin
          if (tbl_angle[k] == it.entry_angle) begin
            r.status = ST_DUP;
            break;
          end
          if (tbl_angle[k] > it.entry_angle && pos == tbl_count) pos = k;
        end
        // duplicate check wins over the full check
        if (r.status == ST_OK) begin
          if (tbl_count >= TABLE_ENTRIES) begin
            r.status = ST_FULL;
          end else begin
            for (int k = tbl_count; k > pos; k--) begin
              tbl_angle[k] = tbl_angle[k-1];
              tbl_gain[k]  = tbl_gain[k-1];
            end
            tbl_angle[pos] = it.entry_angle;
            tbl_gain[pos]  = it.entry_gain;
            tbl_count++;
          end
        end
      end
      OP_QUERY: begin
        r.angle = off_axis_code(it.quat_y, it.quat_z);
        has0    = 0;
        has180  = 0;
        for (int k = 0; k < tbl_count; k++) begin
          if (tbl_angle[k] == 16'd0) has0 = 1;
          if (tbl_angle[k] == 16'hFFFF) has180 = 1;
        end
        if (!has0 || !has180) r.status = ST_NO_END;
        else r.gain = gain_at(r.angle);
      end
      default: ;  // unused op code: nothing happens
    endcase
    return r;
  endfunction

  // directed table: op, angle, gain, y, z, whether a typed result applies
  typedef struct {
    logic [1:0]         op;
    logic [15:0]        ang;
    logic [31:0]        gn;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    bit                 typed;
    out_item_t          res;
  } row_t;

  row_t directed [] = '{
    // query on an empty table: endpoints missing, angle still computed
    '{OP_QUERY,  16'd0,     32'd0,          16'sd0,      16'sd0,      1, '{ST_NO_END, 32'd0, 16'd0}},
    '{OP_INSERT, 16'd0,     32'h0001_0000,  16'sd0,      16'sd0,      1, '{ST_OK, 32'd0, 16'd0}},
    // duplicate angle is ignored
    '{OP_INSERT, 16'd0,     32'hFFFF_FFFF,  16'sd0,      16'sd0,      1, '{ST_DUP, 32'd0, 16'd0}},
    '{OP_QUERY,  16'd0,     32'd0,          16'sd0,      16'sd0,      1, '{ST_NO_END, 32'd0, 16'd0}},
    '{OP_INSERT, 16'hFFFF,  32'hFFFF_FFFF,  16'sd0,      16'sd0,      1, '{ST_OK, 32'd0, 16'd0}},
    // on axis: exact 0 breakpoint gain
    '{OP_QUERY,  16'd0,     32'd0,          16'sd0,      16'sd0,      1, '{ST_OK, 32'h0001_0000, 16'd0}},
    '{OP_INSERT, 16'h8000,  32'h0000_0000,  16'sd0,      16'sd0,      0, '{ST_OK, 32'd0, 16'd0}},
    '{OP_QUERY,  16'd0,     32'd0,          16'sd23170,  16'sd0,      0, '{ST_OK, 32'd0, 16'd0}},
    '{OP_QUERY,  16'd0,     32'd0,          16'sd0,      16'sd32767,  0, '{ST_OK, 32'd0, 16'd0}},
    // non-unit quaternions clamp to 180 degrees
    '{OP_QUERY,  16'd0,     32'd0,          -16'sd32768, -16'sd32768, 1, '{ST_OK, 32'hFFFF_FFFF, 16'hFFFF}},
    '{OP_QUERY,  16'd0,     32'd0,          16'sd32767,  -16'sd32768, 1, '{ST_OK, 32'hFFFF_FFFF, 16'hFFFF}},
    '{OP_QUERY,  16'd0,     32'd0,          -16'sd12000, 16'sd9000,   0, '{ST_OK, 32'd0, 16'd0}},
    // unused op code gives an all-zero result
    '{OP_NONE,   16'hFFFF,  32'hFFFF_FFFF,  -16'sd1,     -16'sd1,     1, '{ST_OK, 32'd0, 16'd0}},
    '{OP_CLEAR,  16'hFFFF,  32'hFFFF_FFFF,  -16'sd1,     -16'sd1,     1, '{ST_OK, 32'd0, 16'd0}},
    '{OP_QUERY,  16'd0,     32'd0,          16'sd0,      16'sd0,      1, '{ST_NO_END, 32'd0, 16'd0}},
    // only the 180 degree end present
    '{OP_INSERT, 16'hFFFF,  32'h1234_5678,  16'sd0,      16'sd0,      1, '{ST_OK, 32'd0, 16'd0}},
    '{OP_QUERY,  16'd0,     32'd0,          16'sd0,      16'sd0,      1, '{ST_NO_END, 32'd0, 16'd0}},
    '{OP_CLEAR,  16'd0,     32'd0,          16'sd0,      16'sd0,      1, '{ST_OK, 32'd0, 16'd0}}
  };

  // drive one item and wait for its transfer, with random gaps before it
  task automatic send_item(input in_item_t it);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // fill the table to capacity in random order, ends included
  task automatic fill_table();
    in_item_t it;
    it = '0;
    it.op = OP_CLEAR;
    send_item(it);
    for (int k = 0; k < TABLE_ENTRIES + 2; k++) begin
      it.op          = OP_INSERT;
      it.entry_angle = k == 0 ? 16'd0 : k == 1 ? 16'hFFFF : 16'($urandom);
      it.entry_gain  = $urandom;
      send_item(it);
    end
  endtask

  // random item: mostly inserts and queries on a table with both ends
  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    it.entry_angle = 16'($urandom);
    it.entry_gain  = $urandom;
    it.quat_y      = 16'($urandom);
    it.quat_z      = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 2) it.op = OP_CLEAR;
    else if (pick < 4) it.op = OP_NONE;
    else if (pick < 40) it.op = OP_INSERT;
    else it.op = OP_QUERY;
    if (it.op == OP_INSERT && $urandom_range(0, 5) == 0)
      it.entry_angle = $urandom_range(0, 1) ? 16'd0 : 16'hFFFF;
    if (it.op == OP_QUERY) begin
      // keep half the queries within unit length so the angle spreads out
      case ($urandom_range(0, 3))
        0: begin
          it.quat_y = 16'($signed(16'($urandom_range(0, 23170))) *
                          ($urandom_range(0, 1) ? 1 : -1));
          it.quat_z = 16'($signed(16'($urandom_range(0, 23170))) *
                          ($urandom_range(0, 1) ? 1 : -1));
        end
        1: begin
          it.quat_y = 16'($signed(16'($urandom_range(0, 2000))) - 1000);
          it.quat_z = 16'($signed(16'($urandom_range(0, 2000))) - 1000);
        end
        default: ;
      endcase
    end
    return it;
  endfunction

  // receiver: random stall bursts, one long hold-off, none at the end
  initial begin
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (600) @(negedge clk);
        out_stall <= 1'b0;
        hold_off  = 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // result checker: every transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: %p", out_item);
        error_count++;
      end else begin
        automatic out_item_t want = pending_results.pop_front();
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_item.status);
          error_count++;
        end
        if (out_item.gain !== want.gain) begin
          $error("gain: expected %h, actual %h", want.gain, out_item.gain);
          error_count++;
        end
        if (out_item.angle !== want.angle) begin
          $error("angle: expected %0d, actual %0d", want.angle, out_item.angle);
          error_count++;
        end
      end
    end
  end

  // predictor: expectation from every accepted input transfer
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) pending_results.push_back(table_step(in_item));
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // stimulus
  initial begin
    in_item_t it;
    out_item_t got_typed;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_item     <= '0;
    tbl_count   = 0;
    error_count = 0;
    idle_cycles = 0;
    calm        = 0;
    hold_off    = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows; typed results are cross-checked with the predictor
    foreach (directed[i]) begin
      it = '{directed[i].op, directed[i].ang, directed[i].gn, directed[i].qy,
             directed[i].qz};
      send_item(it);
      if (directed[i].typed) begin
        got_typed = pending_results[$];
        if (got_typed !== directed[i].res) begin
          $error("row %0d: expected %p, predicted %p", i, directed[i].res, got_typed);
          error_count++;
        end
      end
    end

    // full table, including full-table rejects and the long hold-off
    fill_table();
    hold_off = 1;
    for (int n = 0; n < 40; n++) begin
      it = random_item();
      if (it.op == OP_CLEAR) it.op = OP_QUERY;
      send_item(it);
    end
    fill_table();

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - 200) calm = 1;
      it = random_item();
      // three clears in four are followed by the two ends so queries get past the check
      send_item(it);
      if (it.op == OP_CLEAR && $urandom_range(0, 3) != 0) begin
        it.op = OP_INSERT; it.entry_angle = 16'd0; it.entry_gain = $urandom;
        send_item(it);
        it.entry_angle = 16'hFFFF; it.entry_gain = $urandom;
        send_item(it);
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
